// ----- src/swm_pkg.sv -----
// ----------------------------------------------------------------------------
// swm_pkg
// Shared types and fixed widths for the sliding window maximum block.
// ----------------------------------------------------------------------------
`default_nettype none

package swm_pkg;

  // widths fixed by the stream fields and the configuration register
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned CFG_WIDTH  = 11;

  // operation of the shared compare unit
  typedef enum logic {
    CMP_DIST,  // position distance against window length
    CMP_VAL    // stored value against incoming sample
  } cmp_mode_e;

endpackage

`default_nettype wire

// ----- src/sliding_window_maximum.sv -----
// ----------------------------------------------------------------------------
// sliding_window_maximum
// Each sample first expires front entries that have left the window, then
//   pops back entries smaller than itself, then is pushed; a finished sample
//   waits while the result register is busy. An empty deque skips to the push.
// Samples are taken one at a time, in_stall_o high until the push, a pace
//   set by the single read port of the deque memory and the one compare unit.
// Reset: control and window length (1) cleared at once, deque memory is not.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_maximum
  import swm_pkg::*;
#(
  parameter int unsigned WINDOW_MAX   = 1024,
  parameter int unsigned SAMPLE_WIDTH = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_WIDTH-1:0]  cfg_window_length_i,
  // sample stream
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [DATA_WIDTH-1:0] sample_value_i,
  input  wire logic                  last_sample_i,
  // result stream
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [DATA_WIDTH-1:0]      window_max_o,
  output logic                       last_result_o
);

  localparam int unsigned VW = (SAMPLE_WIDTH < DATA_WIDTH) ? SAMPLE_WIDTH : DATA_WIDTH;
  localparam int unsigned IW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int unsigned PW = $clog2(WINDOW_MAX) + 1;
  localparam int unsigned LW = $clog2(WINDOW_MAX + 1);
  localparam int unsigned MW = VW + PW;
  localparam logic [IW-1:0] LAST_IDX = IW'(WINDOW_MAX - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FRONT,
    S_BACK,
    S_PUSH
  } state_e;

  state_e        state_q, state_d;
  logic [IW-1:0] head_q, head_d;
  logic [IW-1:0] tail_q, tail_d, tail_p;
  logic [LW-1:0] cnt_q, cnt_d, cnt_p;
  logic [PW-1:0] pos_q, pos_d;
  logic [LW-1:0] fill_q, fill_d;
  logic          full_q, full_d;
  logic [LW-1:0] win_q, win_d;
  logic [VW-1:0] val_q, val_d;
  logic          last_q, last_d;
  logic [VW-1:0] front_q, front_d;
  logic          out_valid_q, out_valid_d;
  logic [VW-1:0] out_max_q, out_max_d;
  logic          out_last_q, out_last_d;

  logic          in_acc;
  logic          out_free;
  logic          done;
  logic          full_now;
  logic          finish;
  logic [IW-1:0] head_nx, tail_pv, tail_pv2, push_nx;
  logic [IW-1:0] rd_addr;
  logic [MW-1:0] rd_data;
  logic [VW-1:0] rd_val;
  logic [PW-1:0] rd_pos;
  logic          mem_we;
  cmp_mode_e     cmp_mode;
  logic          hit;

  assign in_acc      = in_valid_i && !in_stall_o;
  assign in_stall_o  = state_q != S_IDLE;
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;

  assign out_valid_o   = out_valid_q;
  assign window_max_o  = DATA_WIDTH'(out_max_q);
  assign last_result_o = out_last_q;

  // ring index steps
  assign head_nx  = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
  assign tail_pv  = (tail_q == '0) ? LAST_IDX : tail_q - 1'b1;
  assign tail_pv2 = (tail_pv == '0) ? LAST_IDX : tail_pv - 1'b1;
  assign push_nx  = (tail_p == LAST_IDX) ? '0 : tail_p + 1'b1;

  assign rd_val = rd_data[PW +: VW];
  assign rd_pos = rd_data[PW-1:0];

  assign cmp_mode = (state_q == S_FRONT) ? CMP_DIST : CMP_VAL;

  swm_ram #(
    .DEPTH (WINDOW_MAX),
    .WIDTH (MW),
    .AW    (IW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (tail_p),
    .wdata_i ({val_q, pos_q}),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  swm_cmp #(
    .VW (VW),
    .PW (PW),
    .LW (LW)
  ) u_cmp (
    .mode_i    (cmp_mode),
    .pos_i     (pos_q),
    .ref_pos_i (rd_pos),
    .len_i     (win_q),
    .val_i     (rd_val),
    .ref_val_i (val_q),
    .hit_o     (hit)
  );

  // window length: zero acts as one, oversize clamps to the deque depth
  always_comb begin
    win_d = win_q;
    if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_window_length_i == '0) begin
        win_d = LW'(1);
      end else if (32'(cfg_window_length_i) > 32'(WINDOW_MAX)) begin
        win_d = LW'(WINDOW_MAX);
      end else begin
        win_d = LW'(cfg_window_length_i);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    head_d  = head_q;
    tail_p  = tail_q;
    cnt_p   = cnt_q;
    front_d = front_q;
    val_d   = val_q;
    last_d  = last_q;
    rd_addr = head_q;
    done    = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          val_d  = sample_value_i[VW-1:0];
          last_d = last_sample_i;
          if (cnt_q == '0) begin
            state_d = S_PUSH;
          end else begin
            state_d = S_FRONT;
          end
        end
      end
      S_FRONT: begin
        if (hit) begin
          // front entry has left the window
          head_d  = head_nx;
          cnt_p   = cnt_q - 1'b1;
          rd_addr = head_nx;
          if (cnt_q == LW'(1)) begin
            done = 1'b1;
          end
        end else begin
          front_d = rd_val;
          rd_addr = tail_pv;
          state_d = S_BACK;
        end
      end
      S_BACK: begin
        if (hit) begin
          tail_p  = tail_pv;
          cnt_p   = cnt_q - 1'b1;
          rd_addr = tail_pv2;
          if (cnt_q == LW'(1)) begin
            done = 1'b1;
          end
        end else begin
          done = 1'b1;
        end
      end
      S_PUSH: begin
        done = 1'b1;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    full_now = full_q || (({1'b0, fill_q} + 1'b1) >= {1'b0, win_q});
    finish   = done && (!full_now || out_free);

    tail_d      = tail_p;
    cnt_d       = cnt_p;
    pos_d       = pos_q;
    fill_d      = fill_q;
    full_d      = full_q;
    mem_we      = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    out_max_d   = out_max_q;
    out_last_d  = out_last_q;

    if (done) begin
      if (finish) begin
        mem_we  = 1'b1;
        tail_d  = push_nx;
        cnt_d   = cnt_p + 1'b1;
        pos_d   = pos_q + 1'b1;
        fill_d  = full_now ? fill_q : fill_q + 1'b1;
        full_d  = full_now;
        state_d = S_IDLE;
        if (full_now) begin
          out_valid_d = 1'b1;
          out_max_d   = (cnt_p == '0) ? val_q : front_q;
          out_last_d  = last_q;
        end
        if (last_q) begin
          head_d = '0;
          tail_d = '0;
          cnt_d  = '0;
          pos_d  = '0;
          fill_d = '0;
          full_d = 1'b0;
        end
      end else begin
        // result register busy, hold the finished sample
        state_d = S_PUSH;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      cnt_q       <= '0;
      pos_q       <= '0;
      fill_q      <= '0;
      full_q      <= 1'b0;
      win_q       <= LW'(1);
      val_q       <= '0;
      last_q      <= 1'b0;
      front_q     <= '0;
      out_valid_q <= 1'b0;
      out_max_q   <= '0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      cnt_q       <= cnt_d;
      pos_q       <= pos_d;
      fill_q      <= fill_d;
      full_q      <= full_d;
      win_q       <= win_d;
      val_q       <= val_d;
      last_q      <= last_d;
      front_q     <= front_d;
      out_valid_q <= out_valid_d;
      out_max_q   <= out_max_d;
      out_last_q  <= out_last_d;
    end
  end

`ifndef SYNTHESIS
  // an empty ring always has head and tail on the same slot
  a_empty_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (head_q == tail_q))
    else $error("deque empty but head and tail differ");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, cnt_q} <= (LW + 1)'(WINDOW_MAX))
    else $error("deque count beyond depth");

  a_push_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q != S_IDLE))
    else $error("deque write while idle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("sample transaction did not start the sequencer");

  a_result_after_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(out_valid_o)) |-> $past(mem_we))
    else $error("result shown without a deque push");
`endif

endmodule

`default_nettype wire

// ----- src/swm_ram.sv -----
// ----------------------------------------------------------------------------
// swm_ram
// Deque storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module swm_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 43,
  parameter int unsigned AW    = 10
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- src/swm_cmp.sv -----
// ----------------------------------------------------------------------------
// swm_cmp
// Shared compare unit: window expiry check at the front, value order at the
// back of the deque.
// ----------------------------------------------------------------------------
`default_nettype none

module swm_cmp
  import swm_pkg::*;
#(
  parameter int unsigned VW = 32,
  parameter int unsigned PW = 11,
  parameter int unsigned LW = 11
) (
  input  wire cmp_mode_e         mode_i,
  input  wire logic [PW-1:0]     pos_i,
  input  wire logic [PW-1:0]     ref_pos_i,
  input  wire logic [LW-1:0]     len_i,
  input  wire logic [VW-1:0]     val_i,
  input  wire logic [VW-1:0]     ref_val_i,
  output logic                   hit_o
);

  localparam int unsigned XW = (PW > LW) ? PW : LW;

  logic [PW-1:0] pos_gap;

  // modular distance, positions wrap harmlessly
  assign pos_gap = pos_i - ref_pos_i;

  always_comb begin
    case (mode_i)
      CMP_DIST: hit_o = XW'(pos_gap) >= XW'(len_i);
      CMP_VAL:  hit_o = val_i < ref_val_i;
      default:  hit_o = 1'b0;
    endcase
  end

endmodule

`default_nettype wire
